>>> design/assert_macros.svh
// Assertion helpers for the queue design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tpq_pkg.sv
// ---------------------------------------------------------------------------
// Time-ordered queue package
// Shared types and operation codes for the sorted priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpq_pkg;

  localparam int unsigned TIME_W = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2
  } tpq_func_t;

  typedef struct packed {
    logic              act;
    logic [TIME_W-1:0] tstamp;
  } tpq_entry_t;

  typedef struct packed {
    logic       push_en;
    logic       pop_en;
    tpq_entry_t entry;
  } tpq_ctrl_t;

endpackage

>>> design/time_ordered_priority_queue.sv
// ---------------------------------------------------------------------------
// Time-ordered priority queue
// Bounded queue of scheduled activities held sorted by time in a chain of
// cells, earliest at the head; equal times leave in arrival order.
// ---------------------------------------------------------------------------
//  channel | direction | fields (lowest bit first)
//  in_     | slave     | tuser: func; tdata: entry_time, entry_activity
//  out_    | master    | tdata: ok, popped_time, popped_activity, head_time,
//          |           |        head_activity, count, is_empty
//
// All cells compare and shift together in the cycle a request is accepted,
// and the result is registered for the next cycle.
// A new request is taken whenever the output register is empty or being read.
// Reset clears the entry count and the output valid flag; the slots need none.
// A stalled output holds its result and blocks further requests.
`timescale 1ns / 1ps

module time_ordered_priority_queue #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CW      = $clog2(CAPACITY + 1),
  localparam int unsigned OUT_BITS = 68 + CW,
  localparam int unsigned OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [31:0] entry_time, [32] entry_activity
  input  logic [39:0]      in_tdata,
  // [1:0] func
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // ok, popped_time, popped_activity, head_time, head_activity, count, is_empty
  output logic [OUT_W-1:0] out_tdata
);

  localparam int unsigned TW = tpq_pkg::TIME_W;

  logic                accept;
  logic                is_push;
  logic                is_pop;
  logic                is_clear;
  logic                push_en;
  logic                pop_en;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  tpq_pkg::tpq_ctrl_t  ctrl;
  tpq_pkg::tpq_entry_t cell_q   [CAPACITY];
  tpq_pkg::tpq_entry_t cell_nxt [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;

  logic                out_valid_r;
  logic                ok_r;
  tpq_pkg::tpq_entry_t popped_r;
  tpq_pkg::tpq_entry_t head_r;
  logic [CW-1:0]       out_count_r;
  logic                empty_r;
  logic [OUT_BITS-1:0] out_bits;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    is_clear = 1'b0;
    unique case (in_tuser)
      tpq_pkg::FUNC_PUSH:  is_push  = 1'b1;
      tpq_pkg::FUNC_POP:   is_pop   = 1'b1;
      tpq_pkg::FUNC_CLEAR: is_clear = 1'b1;
      default: ;
    endcase
  end

  assign push_en = accept && is_push && (count_r != CW'(CAPACITY));
  assign pop_en  = accept && is_pop && (count_r != '0);

  assign ctrl.push_en      = push_en;
  assign ctrl.pop_en       = pop_en;
  assign ctrl.entry.tstamp = in_tdata[TW-1:0];
  assign ctrl.entry.act    = in_tdata[TW];

  always_comb begin
    priority if (accept && is_clear) begin
      count_nxt = '0;
    end else if (push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_en) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tpq_pkg::tpq_entry_t left_entry;
    tpq_pkg::tpq_entry_t right_entry;
    logic                left_gt;

    if (i == 0) begin : g_first
      assign left_entry = ctrl.entry;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_q[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = cell_q[i];
    end else begin : g_mid
      assign right_entry = cell_q[i+1];
    end

    tpq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry_q     (cell_q[i]),
      .entry_nxt   (cell_nxt[i]),
      .gt          (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r        <= push_en || pop_en || is_clear;
      popped_r    <= pop_en ? cell_q[0] : '0;
      head_r      <= (count_nxt != '0) ? cell_nxt[0] : '0;
      out_count_r <= count_nxt;
      empty_r     <= count_nxt == '0;
    end
  end

  assign out_bits = {empty_r, out_count_r, head_r.act, head_r.tstamp,
                     popped_r.act, popped_r.tstamp, ok_r};
  assign out_tdata  = OUT_W'(out_bits);
  assign out_tvalid = out_valid_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (count_r == '0) && !out_valid_r,
                 "reset did not clear the entry count and output valid flag")
  `ASSERT_CLK(a_count_bound, count_r <= CW'(CAPACITY), "entry count exceeds capacity")
  `ASSERT_CLK(a_clear_empties, accept && is_clear |=> count_r == '0, "clear left entries")
  `ASSERT_CLK(a_push_counts, push_en |=> count_r == $past(count_r) + CW'(1),
              "accepted push did not add one entry")
  `ASSERT_CLK(a_empty_flag, out_valid_r |-> (empty_r == (out_count_r == '0)),
              "empty flag disagrees with reported count")

endmodule

>>> design/tpq_cell.sv
// ---------------------------------------------------------------------------
// Queue cell
// One slot of the sorted chain: compares its entry with a pushed one and
// shifts right on insertion or left on removal.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  logic               clk,
  input  tpq_pkg::tpq_ctrl_t ctrl,
  input  logic [CW-1:0]      count,
  input  tpq_pkg::tpq_entry_t left_entry,
  input  logic               left_gt,
  input  tpq_pkg::tpq_entry_t right_entry,
  output tpq_pkg::tpq_entry_t entry_q,
  output tpq_pkg::tpq_entry_t entry_nxt,
  output logic               gt
);

  tpq_pkg::tpq_entry_t entry_r;
  logic                occupied;
  logic                at_count;

  assign occupied = CW'(INDEX) < count;
  assign at_count = CW'(INDEX) == count;
  assign gt       = occupied && (entry_r.tstamp > ctrl.entry.tstamp);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push_en) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || at_count) begin
        entry_nxt = ctrl.entry;
      end
    end else if (ctrl.pop_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// Time-ordered priority queue testbench
// Drives push, pop, clear and unused-code requests into the sorted queue and
// checks every result against a queue kept in the testbench. Covers
// - ordering by time, including ties;
// - a full queue and an empty queue;
// - back-pressure while the output is held off for a long stretch;
// - random idling on both sides, with a final stretch at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // Result fields packed from the top bit down, so that ok lands in bit 0.
  typedef struct packed {
    logic        is_empty;
    logic [4:0]  count;
    logic        head_act;
    logic [31:0] head_time;
    logic        popped_act;
    logic [31:0] popped_time;
    logic        ok;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  tpq_pkg::tpq_entry_t sched_entries[$];
  sched_result_t       expected_results[$];

  bit          idle_enabled = 1'b1;
  int unsigned hold_request = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned n_results = 0;
  int unsigned n_push_ok = 0;
  int unsigned n_push_full = 0;
  int unsigned n_pop_ok = 0;
  int unsigned n_pop_empty = 0;
  int unsigned n_clear = 0;
  int unsigned n_nop = 0;

  time_ordered_priority_queue #(.CAPACITY(CAPACITY)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic sched_result_t predict_queue_op(logic [1:0] func, logic [31:0] t,
                                                     logic act);
    sched_result_t       r;
    tpq_pkg::tpq_entry_t e;
    int unsigned         pos;
    r = '0;
    e.tstamp = t;
    e.act = act;
    case (func)
      tpq_pkg::FUNC_PUSH: begin
        if (sched_entries.size() < CAPACITY) begin
          pos = 0;
          while (pos < sched_entries.size() && sched_entries[pos].tstamp <= t) pos++;
          sched_entries.insert(pos, e);
          r.ok = 1'b1;
          n_push_ok++;
        end else begin
          n_push_full++;
        end
      end
      tpq_pkg::FUNC_POP: begin
        if (sched_entries.size() != 0) begin
          e = sched_entries.pop_front();
          r.ok = 1'b1;
          r.popped_time = e.tstamp;
          r.popped_act = e.act;
          n_pop_ok++;
        end else begin
          n_pop_empty++;
        end
      end
      tpq_pkg::FUNC_CLEAR: begin
        sched_entries.delete();
        r.ok = 1'b1;
        n_clear++;
      end
      default: begin
        n_nop++;
      end
    endcase
    if (sched_entries.size() != 0) begin
      r.head_time = sched_entries[0].tstamp;
      r.head_act = sched_entries[0].act;
    end
    r.count = 5'(sched_entries.size());
    r.is_empty = (sched_entries.size() == 0);
    return r;
  endfunction

  function automatic logic [31:0] pick_time();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 7));
      5: return 32'hFFFF_FFF8 | 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      note_failure($sformatf("Result %0d, %s: expected %h, got %h", n_results, name, want,
                             got));
    end
  endtask

  always @(posedge clk) begin : result_check
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sched_result_t'(out_tdata[72:0]);
      if (expected_results.size() == 0) begin
        note_failure($sformatf("Unexpected result %h with no request outstanding.", got));
      end else begin
        want = expected_results.pop_front();
        compare_field("ok", 32'(want.ok), 32'(got.ok));
        compare_field("popped_time", want.popped_time, got.popped_time);
        compare_field("popped_activity", 32'(want.popped_act), 32'(got.popped_act));
        compare_field("head_time", want.head_time, got.head_time);
        compare_field("head_activity", 32'(want.head_act), 32'(got.head_act));
        compare_field("count", 32'(want.count), 32'(got.count));
        compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      end
      n_results++;
    end
  end

  initial begin : receiver
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [1:0] func, logic [31:0] t, logic act);
    int unsigned gap;
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {7'b0, act, t};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_queue_op(func, t, act));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(tpq_pkg::FUNC_POP, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_NONE, 32'h0000_0000, 1'b0);
    send_request(tpq_pkg::FUNC_CLEAR, 32'h1234_5678, 1'b1);
    send_request(tpq_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 1'b1);
    send_request(tpq_pkg::FUNC_PUSH, 32'h0000_0000, 1'b0);
    send_request(tpq_pkg::FUNC_PUSH, 32'h0000_0005, 1'b1);
    send_request(tpq_pkg::FUNC_PUSH, 32'h0000_0005, 1'b0);
    send_request(tpq_pkg::FUNC_PUSH, 32'h0000_0005, 1'b1);
    send_request(FUNC_NONE, 32'hFFFF_FFFF, 1'b1);
    send_request(tpq_pkg::FUNC_POP, 32'h0000_0000, 1'b0);
    send_request(tpq_pkg::FUNC_POP, 32'h0000_0000, 1'b0);
    send_request(tpq_pkg::FUNC_POP, 32'h0000_0000, 1'b0);
    send_request(tpq_pkg::FUNC_CLEAR, 32'h0000_0000, 1'b0);
    send_request(tpq_pkg::FUNC_POP, 32'h0000_0000, 1'b0);
    send_request(tpq_pkg::FUNC_PUSH, 32'h8000_0000, 1'b1);
    send_request(tpq_pkg::FUNC_POP, 32'h0000_0000, 1'b0);
    wait_for_results();
  endtask

  // The output is held off at first, so the input stalls behind the held result;
  // more pushes than the capacity then fill the queue, which refuses pushes when full.
  task automatic test_hold_off();
    int unsigned k;
    send_request(tpq_pkg::FUNC_CLEAR, 32'h0, 1'b0);
    hold_request = 80;
    for (k = 0; k < 20; k++) begin
      send_request(tpq_pkg::FUNC_PUSH, pick_time(), 1'($urandom_range(0, 1)));
    end
    for (k = 0; k < 18; k++) begin
      send_request(tpq_pkg::FUNC_POP, $urandom, 1'($urandom_range(0, 1)));
    end
    wait_for_results();
  endtask

  // Traffic runs in stretches that each lean towards filling or draining, chosen
  // at random, so that the count sweeps the whole range.
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned k;
    int unsigned sel;
    logic [1:0]  func;
    bit          filling;
    filling = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) filling = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      if (sel < 2) func = tpq_pkg::FUNC_CLEAR;
      else if (sel < 5) func = FUNC_NONE;
      else if (sel < (filling ? 78 : 35)) func = tpq_pkg::FUNC_PUSH;
      else func = tpq_pkg::FUNC_POP;
      send_request(func, pick_time(), 1'($urandom_range(0, 1)));
      if (k % 250 == 249) wait_for_results();
    end
  endtask

  task automatic test_full_rate();
    idle_enabled = 1'b0;
    test_random_traffic(300);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_hold_off();
    test_random_traffic(1500);
    test_full_rate();
    wait_for_results();
    repeat (4) @(posedge clk);
    $display("Checked %0d results: %0d pushes taken, %0d refused when full, %0d pops,",
             n_results, n_push_ok, n_push_full, n_pop_ok);
    $display("%0d pops on empty, %0d clears and %0d unused codes; %0d failures.",
             n_pop_empty, n_clear, n_nop, fail_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/tpq_pkg.sv
design/tpq_cell.sv
design/time_ordered_priority_queue.sv
tb/tb.sv
